>>> hdl/msd_pkg.sv
`timescale 1ns / 1ps

package msd_pkg;

    localparam int unsigned HDR_BYTES = 8;
    localparam int unsigned HDR_IDX_W = $clog2(HDR_BYTES);

    localparam logic [7:0]  TYPE_STDOUT = 8'd1;
    localparam logic [7:0]  TYPE_STDERR = 8'd2;

    localparam logic [31:0] MAX_LEN_RESET = 32'd16777216;

    localparam logic        CH_STDOUT = 1'b0;
    localparam logic        CH_STDERR = 1'b1;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       channel;
        logic       frame_end;
        logic       last;
    } beat_t;

endpackage

>>> hdl/msd_out_reg.sv
`timescale 1ns / 1ps

module msd_out_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  msd_pkg::beat_t load_beat,
    input  logic          out_ready,
    output logic          out_valid,
    output msd_pkg::beat_t beat,
    output logic          fire,
    output logic          free
);

    logic           valid_reg;
    logic           valid_next;
    msd_pkg::beat_t beat_reg;

    assign fire       = valid_reg && out_ready;
    assign free       = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (fire ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= load_beat;
        end
    end

    assign out_valid = valid_reg;
    assign beat      = beat_reg;

endmodule

>>> hdl/multiplexed_stream_deframer_top.sv
`timescale 1ns / 1ps
// a result beat is registered and shows on the output in the cycle after its input beat is accepted
// throughput: one input beat per cycle, limited by the single output register
// an oversized header holds off input for the seven further header beats of the dump
// reset: asynchronous active-low rst_n clears control state and sets max_len_reg to 16 MiB
// header byte storage has no reset

module multiplexed_stream_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        chunk_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        channel,
    output logic        frame_end,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int unsigned IW = msd_pkg::HDR_IDX_W;

    logic [31:0]   max_len_reg;
    logic [IW-1:0] hdr_cnt_reg;
    logic [IW-1:0] hdr_cnt_next;
    logic [7:0]    frame_type_reg;
    logic [7:0]    frame_type_next;
    logic [31:0]   payload_left_reg;
    logic [31:0]   payload_left_next;
    logic          pass_reg;
    logic          pass_next;
    logic          dump_reg;
    logic          dump_next;
    logic [IW-1:0] dump_idx_reg;
    logic [IW-1:0] dump_idx_next;
    logic [7:0]    hdr_store [msd_pkg::HDR_BYTES];

    logic           accept;
    logic           hdr_write;
    logic           hdr_done;
    logic           oversize;
    logic           routed;
    logic [31:0]    hdr_len;
    logic           load;
    msd_pkg::beat_t load_beat;
    msd_pkg::beat_t beat;
    logic           fire;
    logic           free;

    assign cfg_ready = 1'b1;
    assign in_ready  = !dump_reg && free;
    assign accept    = in_valid && in_ready;

    assign hdr_write = accept && !pass_reg && (payload_left_reg == 32'd0);
    assign hdr_done  = hdr_write && (hdr_cnt_reg == IW'(msd_pkg::HDR_BYTES - 1));
    assign hdr_len   = {hdr_store[4], hdr_store[5], hdr_store[6], in_byte};
    assign oversize  = hdr_done && (hdr_len > max_len_reg);
    assign routed    = (frame_type_reg == msd_pkg::TYPE_STDOUT) ||
                       (frame_type_reg == msd_pkg::TYPE_STDERR);

    always_comb
    begin
        load              = 1'b0;
        load_beat         = '0;
        hdr_cnt_next      = hdr_cnt_reg;
        frame_type_next   = frame_type_reg;
        payload_left_next = payload_left_reg;
        pass_next         = pass_reg;
        dump_next         = dump_reg;
        dump_idx_next     = dump_idx_reg;

        if (dump_reg && fire)
        begin
            load               = 1'b1;
            load_beat.out_byte = hdr_store[dump_idx_reg];
            load_beat.channel  = msd_pkg::CH_STDOUT;
            load_beat.last     = (dump_idx_reg == IW'(msd_pkg::HDR_BYTES - 1));
            dump_idx_next      = dump_idx_reg + IW'(1);
            if (load_beat.last)
            begin
                dump_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (pass_reg)
            begin
                load               = 1'b1;
                load_beat.out_byte = in_byte;
                load_beat.channel  = msd_pkg::CH_STDOUT;
                load_beat.last     = 1'b1;
                if (chunk_end)
                begin
                    pass_next = 1'b0;
                end
            end
            else if (payload_left_reg != 32'd0)
            begin
                payload_left_next = payload_left_reg - 32'd1;
                if (routed)
                begin
                    load               = 1'b1;
                    load_beat.out_byte = in_byte;
                    load_beat.channel  = (frame_type_reg == msd_pkg::TYPE_STDERR) ?
                                         msd_pkg::CH_STDERR : msd_pkg::CH_STDOUT;
                    load_beat.frame_end = (payload_left_reg == 32'd1);
                    load_beat.last     = 1'b1;
                end
            end
            else
            begin
                hdr_cnt_next = hdr_cnt_reg + IW'(1);
                if (oversize)
                begin
                    // first header byte goes out now, the rest follow from the store
                    load               = 1'b1;
                    load_beat.out_byte = hdr_store[0];
                    load_beat.channel  = msd_pkg::CH_STDOUT;
                    dump_next          = 1'b1;
                    dump_idx_next      = IW'(1);
                    pass_next          = !chunk_end;
                end
                else if (hdr_done)
                begin
                    frame_type_next   = hdr_store[0];
                    payload_left_next = hdr_len;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg      <= msd_pkg::MAX_LEN_RESET;
            hdr_cnt_reg      <= '0;
            frame_type_reg   <= '0;
            payload_left_reg <= '0;
            pass_reg         <= 1'b0;
            dump_reg         <= 1'b0;
            dump_idx_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_len_reg <= cfg_data;
            end
            hdr_cnt_reg      <= hdr_cnt_next;
            frame_type_reg   <= frame_type_next;
            payload_left_reg <= payload_left_next;
            pass_reg         <= pass_next;
            dump_reg         <= dump_next;
            dump_idx_reg     <= dump_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_write)
        begin
            hdr_store[hdr_cnt_reg] <= in_byte;
        end
    end

    msd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_beat (load_beat),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .beat      (beat),
        .fire      (fire),
        .free      (free)
    );

    assign out_byte  = beat.out_byte;
    assign channel   = beat.channel;
    assign frame_end = beat.frame_end;
    assign last      = beat.last;

endmodule

>>> hdl/msd_checker.sv
`timescale 1ns / 1ps

module msd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       channel,
    input logic       frame_end,
    input logic       last
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("output beat changed while stalled");

    // header dump runs without gaps
    a_dump_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("gap inside header dump");

    // input held off during header dump
    a_dump_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input taken during header dump");

    // dumped header bytes go to stdout without frame end
    a_dump_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !channel && !frame_end)
        else $error("bad fields on dumped header beat");

endmodule

bind multiplexed_stream_deframer_top msd_checker u_msd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .channel   (channel),
    .frame_end (frame_end),
    .last      (last)
);
